// ----- src/acsp_pkg.sv -----
package acsp_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int GLYPH_W = 7;

    localparam logic [GLYPH_W-1:0] GLYPH_HEIGHT_RST = 7'd16;
    localparam logic [GLYPH_W-1:0] GLYPH_WIDTH_RST = 7'd8;

    // Register indexes (byte address divided by four).
    localparam logic REG_GLYPH_HEIGHT = 1'b0;
    localparam logic REG_GLYPH_WIDTH = 1'b1;

    // Parser modes.
    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_LEAD = 3'd1;
    localparam logic [2:0] MODE_ESC = 3'd2;
    localparam logic [2:0] MODE_CSI = 3'd3;
    localparam logic [2:0] MODE_PARAM = 3'd4;

    // Command codes on the result channel.
    localparam logic [2:0] CMD_PRINT = 3'd0;
    localparam logic [2:0] CMD_WIDE = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_CLEAR_EOL = 3'd3;
    localparam logic [2:0] CMD_MOVE = 3'd4;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_J = 8'h4A;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_result;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_height;
        logic [GLYPH_W-1:0] glyph_width;
    } t_glyph_cfg;

    function automatic logic is_lead(input logic [7:0] b);
        return b inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    // v * 10 + d, saturated to 16 bits.
    function automatic logic [15:0] acc_dec(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] t;
        t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, d};
        return (t > 20'h0FFFF) ? 16'hFFFF : t[15:0];
    endfunction

    // (max(v,1) - 1) * size, saturated to 16 bits.
    function automatic logic [15:0] scale_pos(input logic [15:0] v,
                                              input logic [GLYPH_W-1:0] size);
        logic [15:0] m;
        logic [15+GLYPH_W:0] p;
        m = (v == 16'd0) ? 16'd0 : v - 16'd1;
        p = {{GLYPH_W{1'b0}}, m} * {16'b0, size};
        return (p > {{GLYPH_W{1'b0}}, 16'hFFFF}) ? 16'hFFFF : p[15:0];
    endfunction

endpackage

// ----- src/ansi_csi_sjis_term_parser.sv -----
// Terminal stream parser: accepts one byte per beat and returns at most one display
// command per byte (print, two-byte Shift-JIS print, clear screen, clear to end of
// line, cursor move in pixels). It takes a new byte every cycle unless a byte with a
// command sits in the input register while the output register waits to be taken;
// a byte is accepted into the input register, parsed there, and its command is loaded
// into the output register when the byte moves on. Bytes that give no command (lead
// bytes, ESC, sequence bytes) move on even while a finished command waits to be taken.
// The glyph height (address 0, reset 16) and glyph width (address 4, reset 8) registers
// scale cursor moves and should only be written while the parser is idle.
module ansi_csi_sjis_term_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_byte_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_command,
    output logic [7:0]                  o_first_byte,
    output logic [7:0]                  o_second_byte,
    output logic [15:0]                 o_pos_x,
    output logic [15:0]                 o_pos_y,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [acsp_pkg::ADDR_W-1:0] paddr,
    input  logic [acsp_pkg::DATA_W-1:0] pwdata,
    output logic [acsp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import acsp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    t_glyph_cfg w_cfg;
    logic       w_has_result;
    t_result    w_result;
    logic       w_advance;

    acsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    acsp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_byte       (r_in_byte),
        .i_cfg        (w_cfg),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    assign w_advance = r_in_valid && (!w_has_result || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_command     = r_out.command;
    assign o_first_byte  = r_out.first_byte;
    assign o_second_byte = r_out.second_byte;
    assign o_pos_x       = r_out.pos_x;
    assign o_pos_y       = r_out.pos_y;

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid)
        else $error("pending command dropped before it was taken");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && w_has_result && r_out_valid && !i_ready))
        else $error("input stalled without a blocked command");

endmodule

// ----- src/acsp_cfg.sv -----
module acsp_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acsp_pkg::ADDR_W-1:0] paddr,
    input  logic [acsp_pkg::DATA_W-1:0] pwdata,
    output logic [acsp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output acsp_pkg::t_glyph_cfg       o_cfg
);
    import acsp_pkg::*;

    logic [GLYPH_W-1:0] r_glyph_height;
    logic [GLYPH_W-1:0] r_glyph_width;
    logic               w_wr;
    logic               w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_height <= GLYPH_HEIGHT_RST;
            r_glyph_width  <= GLYPH_WIDTH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_GLYPH_HEIGHT: r_glyph_height <= pwdata[GLYPH_W-1:0];
                REG_GLYPH_WIDTH:  r_glyph_width  <= pwdata[GLYPH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GLYPH_HEIGHT: prdata = {{(DATA_W-GLYPH_W){1'b0}}, r_glyph_height};
            REG_GLYPH_WIDTH:  prdata = {{(DATA_W-GLYPH_W){1'b0}}, r_glyph_width};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.glyph_height = r_glyph_height;
    assign o_cfg.glyph_width  = r_glyph_width;

endmodule

// ----- src/acsp_parser.sv -----
module acsp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  acsp_pkg::t_glyph_cfg i_cfg,
    output logic                 o_has_result,
    output acsp_pkg::t_result    o_result
);
    import acsp_pkg::*;

    logic [2:0]  r_mode;
    logic [7:0]  r_lead;
    logic [15:0] r_param0;
    logic [15:0] r_param1;
    logic [1:0]  r_count;

    logic [2:0]  n_mode;
    logic [7:0]  n_lead;
    logic [15:0] n_param0;
    logic [15:0] n_param1;
    logic [1:0]  n_count;

    logic [15:0] w_acc;

    // One accumulator serves whichever parameter is open.
    assign w_acc = acc_dec((r_count == 2'd2) ? r_param1 : r_param0, i_byte[3:0]);

    always_comb begin
        n_mode       = r_mode;
        n_lead       = r_lead;
        n_param0     = r_param0;
        n_param1     = r_param1;
        n_count      = r_count;
        o_has_result = 1'b0;
        o_result     = '0;
        case (r_mode)
            MODE_LEAD: begin
                n_mode               = MODE_PLAIN;
                o_has_result         = 1'b1;
                o_result.command     = CMD_WIDE;
                o_result.first_byte  = r_lead;
                o_result.second_byte = i_byte;
            end
            MODE_ESC: begin
                if (i_byte == CH_LBRACKET) begin
                    n_mode  = MODE_CSI;
                    n_count = 2'd0;
                end else begin
                    // A lone ESC is printed and the byte after it is dropped.
                    n_mode              = MODE_PLAIN;
                    o_has_result        = 1'b1;
                    o_result.command    = CMD_PRINT;
                    o_result.first_byte = CH_ESC;
                end
            end
            MODE_CSI: begin
                if (is_digit(i_byte)) begin
                    n_mode   = MODE_PARAM;
                    n_param0 = {12'b0, i_byte[3:0]};
                    n_count  = 2'd1;
                end else begin
                    n_mode = MODE_PLAIN;
                    if (i_byte == CH_K) begin
                        o_has_result     = 1'b1;
                        o_result.command = CMD_CLEAR_EOL;
                    end
                end
            end
            MODE_PARAM: begin
                if (is_digit(i_byte)) begin
                    if (r_count == 2'd1) begin
                        n_param0 = w_acc;
                    end else if (r_count == 2'd2) begin
                        n_param1 = w_acc;
                    end
                end else if (i_byte == CH_SEMI) begin
                    if (r_count == 2'd1) begin
                        n_param1 = 16'd0;
                        n_count  = 2'd2;
                    end else begin
                        n_count = 2'd3;
                    end
                end else begin
                    n_mode = MODE_PLAIN;
                    if (i_byte == CH_J) begin
                        if (r_count == 2'd1 && r_param0 == 16'd2) begin
                            o_has_result     = 1'b1;
                            o_result.command = CMD_CLEAR;
                        end
                    end else if (i_byte == CH_H) begin
                        if (r_count == 2'd2) begin
                            o_has_result     = 1'b1;
                            o_result.command = CMD_MOVE;
                            o_result.pos_x   = scale_pos(r_param1, i_cfg.glyph_width);
                            o_result.pos_y   = scale_pos(r_param0, i_cfg.glyph_height);
                        end
                    end
                end
            end
            default: begin
                n_mode = MODE_PLAIN;
                if (is_lead(i_byte)) begin
                    n_mode = MODE_LEAD;
                    n_lead = i_byte;
                end else if (i_byte == CH_ESC) begin
                    n_mode = MODE_ESC;
                end else begin
                    o_has_result        = 1'b1;
                    o_result.command    = CMD_PRINT;
                    o_result.first_byte = i_byte;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_lead   <= 8'd0;
            r_param0 <= 16'd0;
            r_param1 <= 16'd0;
            r_count  <= 2'd0;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_lead   <= n_lead;
            r_param0 <= n_param0;
            r_param1 <= n_param1;
            r_count  <= n_count;
        end
    end

    a_lead_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_LEAD |->
            ((r_lead >= 8'h81 && r_lead <= 8'h9F) || (r_lead >= 8'hE0 && r_lead <= 8'hFC)))
        else $error("lead mode holds a byte that is not a lead byte");

    a_param_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_PARAM |-> r_count != 2'd0)
        else $error("parameter mode with no parameter begun");

    a_move_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has_result && o_result.command == CMD_MOVE) |->
            (r_mode == MODE_PARAM && r_count == 2'd2 && i_byte == CH_H))
        else $error("cursor move issued outside a two-parameter sequence");

endmodule
